// ----- design/assert_macros.svh -----
// Assertion macros used by the frame store design.
// Define NO_ASSERTIONS to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked only outside reset.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, checked only outside reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/pmfb_pkg.sv -----
`default_nettype none

package pmfb_pkg;

    // Store geometry.
    localparam int DISPLAY_WIDTH = 128;
    localparam int PAGE_COUNT    = 4;
    localparam int STORE_SIZE    = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int ROW_COUNT     = PAGE_COUNT * 8;
    localparam int ADDR_W        = $clog2(STORE_SIZE);
    localparam int ADDR_P1       = ADDR_W + 1;

    // Page index width: holds the last page plus the page past it that a column
    // merge steps to as it ends.
    localparam int PG_W  = 4;
    // Width used to compare a read index against the store size.
    localparam int CMP_W = 12;

    // Glyph widths.
    localparam int SMALL_BYTES = 2;
    localparam int LARGE_BYTES = 4;
    localparam int LARGE_ROWS  = 24;

    typedef enum logic [2:0] {
        OP_FILL_ALL  = 3'd0,
        OP_FILL_PAGE = 3'd1,
        OP_SMALL_COL = 3'd2,
        OP_LARGE_COL = 3'd3,
        OP_READ      = 3'd4
    } op_t;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  column;
        logic [7:0]  row;
        logic [7:0]  page_number;
        logic        color;
        logic [23:0] glyph_bits;
        logic [8:0]  read_index;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } result_t;

    // One access to the single-port store.
    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    // Byte address of a page and column.
    function automatic logic [ADDR_W-1:0] page_addr(input logic [PG_W-1:0] page,
                                                    input logic [7:0] col);
        logic [ADDR_P1-1:0] sum;
        sum = ADDR_P1'(page) * ADDR_P1'(DISPLAY_WIDTH) + ADDR_P1'(col);
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/pmfb_store.sv -----
`default_nettype none

module pmfb_store (
    input  wire logic              clk,
    input  wire pmfb_pkg::mem_req_t req,
    output logic [7:0]             rdata
);

    logic [7:0] mem [pmfb_pkg::STORE_SIZE];
    logic [7:0] rdata_reg;

    // Single port: a write, or a registered read whose data appears in the next cycle.
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/pmfb_seq.sv -----
`default_nettype none
`include "assert_macros.svh"

module pmfb_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire pmfb_pkg::item_t    item,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output pmfb_pkg::result_t       res,
    output pmfb_pkg::mem_req_t      mem_req,
    input  wire logic [7:0]         rdata
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_FILL   = 8'b0000_0100,
        S_RD     = 8'b0000_1000,
        S_WR     = 8'b0001_0000,
        S_RDB    = 8'b0010_0000,
        S_CAPT   = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } state_t;

    state_t                         state_reg, state_next;
    logic [pmfb_pkg::ADDR_W-1:0]    addr_reg, addr_next;
    logic [pmfb_pkg::ADDR_W-1:0]    end_reg, end_next;
    logic [7:0]                     fill_reg, fill_next;
    logic                           color_reg, color_next;
    logic [31:0]                    word_reg, word_next;
    logic [pmfb_pkg::PG_W-1:0]      page_reg, page_next;
    logic [2:0]                     left_reg, left_next;
    logic [7:0]                     col_reg, col_next;
    logic [7:0]                     data_reg, data_next;
    logic                           status_reg, status_next;

    logic [pmfb_pkg::ADDR_W-1:0]    rmw_addr;
    logic [7:0]                     merged;
    logic                           col_bad;
    logic [pmfb_pkg::PG_W-1:0]      page_inc;

    assign rmw_addr = pmfb_pkg::page_addr(page_reg, col_reg);
    assign merged   = color_reg ? (rdata | word_reg[7:0]) : (rdata & ~word_reg[7:0]);
    assign col_bad  = {1'b0, item.column} >= 9'(pmfb_pkg::DISPLAY_WIDTH);
    assign page_inc = page_reg + {{(pmfb_pkg::PG_W-1){1'b0}}, 1'b1};

    assign item_ready     = (state_reg == S_IDLE);
    assign res_valid      = (state_reg == S_RESULT);
    assign res.read_data  = data_reg;
    assign res.status     = status_reg;

    // Store port: clear/fill sweep writes, merge read then write, byte read.
    always_comb
    begin
        mem_req.en    = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = addr_reg;
        mem_req.wdata = fill_reg;
        unique case (state_reg) inside
            S_CLEAR, S_FILL:
            begin
                mem_req.en = 1'b1;
                mem_req.we = 1'b1;
            end
            S_RD:
            begin
                mem_req.en   = 1'b1;
                mem_req.addr = rmw_addr;
            end
            S_WR:
            begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = rmw_addr;
                mem_req.wdata = merged;
            end
            S_RDB:
            begin
                mem_req.en = 1'b1;
            end
            default:
            begin
                mem_req.en = 1'b0;
            end
        endcase
    end

    // Sequencer: decode a transaction, walk its store accesses, hold the result.
    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        end_next    = end_reg;
        fill_next   = fill_reg;
        color_next  = color_reg;
        word_next   = word_reg;
        page_next   = page_reg;
        left_next   = left_reg;
        col_next    = col_reg;
        data_next   = data_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (addr_reg == end_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + pmfb_pkg::ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    data_next   = 8'h00;
                    status_next = pmfb_pkg::STATUS_DONE;
                    color_next  = item.color;
                    fill_next   = {8{item.color}};
                    col_next    = item.column;
                    state_next  = S_RESULT;
                    unique case (item.op)
                        pmfb_pkg::OP_FILL_ALL:
                        begin
                            addr_next  = '0;
                            end_next   = pmfb_pkg::ADDR_W'(pmfb_pkg::STORE_SIZE - 1);
                            state_next = S_FILL;
                        end
                        pmfb_pkg::OP_FILL_PAGE:
                        begin
                            if (item.page_number >= 8'(pmfb_pkg::PAGE_COUNT))
                            begin
                                status_next = pmfb_pkg::STATUS_IGNORED;
                            end
                            else
                            begin
                                addr_next = pmfb_pkg::page_addr(
                                    item.page_number[pmfb_pkg::PG_W-1:0], 8'h00);
                                end_next  = pmfb_pkg::page_addr(
                                    item.page_number[pmfb_pkg::PG_W-1:0],
                                    8'(pmfb_pkg::DISPLAY_WIDTH - 1));
                                state_next = S_FILL;
                            end
                        end
                        pmfb_pkg::OP_SMALL_COL:
                        begin
                            if (item.row >= 8'(pmfb_pkg::ROW_COUNT) || col_bad)
                            begin
                                status_next = pmfb_pkg::STATUS_IGNORED;
                            end
                            else
                            begin
                                word_next  = {24'h0, item.glyph_bits[7:0]} << item.row[2:0];
                                page_next  = pmfb_pkg::PG_W'(item.row[7:3]);
                                left_next  = 3'(pmfb_pkg::SMALL_BYTES);
                                state_next = S_RD;
                            end
                        end
                        pmfb_pkg::OP_LARGE_COL:
                        begin
                            if ({1'b0, item.row} + 9'(pmfb_pkg::LARGE_ROWS)
                                > 9'(pmfb_pkg::ROW_COUNT) || col_bad)
                            begin
                                status_next = pmfb_pkg::STATUS_IGNORED;
                            end
                            else
                            begin
                                word_next  = {8'h0, item.glyph_bits} << item.row[2:0];
                                page_next  = pmfb_pkg::PG_W'(item.row[7:3]);
                                left_next  = 3'(pmfb_pkg::LARGE_BYTES);
                                state_next = S_RD;
                            end
                        end
                        pmfb_pkg::OP_READ:
                        begin
                            if (pmfb_pkg::CMP_W'(item.read_index)
                                >= pmfb_pkg::CMP_W'(pmfb_pkg::STORE_SIZE))
                            begin
                                status_next = pmfb_pkg::STATUS_IGNORED;
                            end
                            else
                            begin
                                addr_next  = pmfb_pkg::ADDR_W'(item.read_index);
                                state_next = S_RDB;
                            end
                        end
                        default:
                        begin
                            status_next = pmfb_pkg::STATUS_IGNORED;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                if (addr_reg == end_reg)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    addr_next = addr_reg + pmfb_pkg::ADDR_W'(1);
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                word_next = word_reg >> 8;
                page_next = page_inc;
                left_next = left_reg - 3'd1;
                if (left_reg == 3'd1 || page_inc >= pmfb_pkg::PG_W'(pmfb_pkg::PAGE_COUNT))
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RDB:
            begin
                state_next = S_CAPT;
            end
            S_CAPT:
            begin
                data_next  = rdata;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // After reset the sequencer sweeps the whole store with zeros.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            addr_reg   <= '0;
            end_reg    <= pmfb_pkg::ADDR_W'(pmfb_pkg::STORE_SIZE - 1);
            fill_reg   <= 8'h00;
            color_reg  <= 1'b0;
            word_reg   <= '0;
            page_reg   <= '0;
            left_reg   <= '0;
            col_reg    <= '0;
            data_reg   <= '0;
            status_reg <= pmfb_pkg::STATUS_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            end_reg    <= end_next;
            fill_reg   <= fill_next;
            color_reg  <= color_next;
            word_reg   <= word_next;
            page_reg   <= page_next;
            left_reg   <= left_next;
            col_reg    <= col_next;
            data_reg   <= data_next;
            status_reg <= status_next;
        end
    end

    // While waiting for a transaction the store is left alone.
    `ASSERT_IMPLIES(a_idle_no_access, clk, rst_n, state_reg == S_IDLE, !mem_req.en)
    // A merge read is always followed by its write.
    `ASSERT_NEXT(a_read_then_write, clk, rst_n, state_reg == S_RD, state_reg == S_WR)
    // The write of a merge goes to the byte that was just read.
    `ASSERT_IMPLIES(a_rmw_same_addr, clk, rst_n, state_reg == S_WR, mem_req.addr == $past(mem_req.addr))
    // A merge never runs with no bytes left to do.
    `ASSERT_IMPLIES(a_bytes_left, clk, rst_n, state_reg == S_RD || state_reg == S_WR, left_reg != 3'd0)

endmodule

`default_nettype wire

// ----- design/paged_mono_framebuffer_blit.sv -----
// A rejected transaction goes straight to its result; a read issues one store read and
// captures its data; a column merge reads and writes back each page byte in turn, up to
// the last page; a fill writes each byte of one page or of the whole store in turn.
// One transaction is in work at a time; the next one is taken once the sequencer has
// handed its result to the output register.
// After reset a clearing pass zeroes the store with item_ready low.
`default_nettype none

module paged_mono_framebuffer_blit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire pmfb_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output pmfb_pkg::result_t      result
);

    pmfb_pkg::mem_req_t mem_req;
    logic [7:0]         rdata;
    logic               res_valid;
    logic               res_ready;
    pmfb_pkg::result_t  res;

    logic               result_valid_reg;
    pmfb_pkg::result_t  result_reg;

    pmfb_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    pmfb_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_req    (mem_req),
        .rdata      (rdata)
    );

    // Output register: frees the sequencer while a result waits to be taken.
    assign res_ready = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            result_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import pmfb_pkg::*;

    // Opcodes the block does not implement; they must be rejected.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // Cycles with no transaction on either channel before the run is abandoned.
    // The slowest legal pause is the reset clearing pass or a whole-store fill
    // followed by the longest receiver stall, well under this.
    localparam int STALL_LIMIT = 5000;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    // Predicted store contents and the results still owed by the block.
    logic [7:0] pixel_bytes [0:STORE_SIZE-1];
    result_t    owed_results[$];
    int         mismatch_count = 0;
    int         quiet_cycles;
    bit         no_idling;

    paged_mono_framebuffer_blit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Random idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        if (no_idling)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Merge one byte into the predicted store, dropping pages past the last one.
    function automatic void blend_byte(int unsigned pg, int unsigned col,
                                       logic [7:0] bits, logic color);
        int unsigned idx;
        if (pg >= PAGE_COUNT || col >= DISPLAY_WIDTH)
            return;
        idx = pg * DISPLAY_WIDTH + col;
        if (color)
            pixel_bytes[idx] = pixel_bytes[idx] | bits;
        else
            pixel_bytes[idx] = pixel_bytes[idx] & ~bits;
    endfunction

    // Apply one drawing or read transaction to the predicted store and return its result.
    function automatic result_t apply_draw_op(item_t it);
        result_t     res;
        logic [7:0]  fill_byte;
        logic [31:0] shifted;
        int unsigned pg;
        int unsigned sh;
        int          i;
        res.read_data = 8'h00;
        res.status    = STATUS_DONE;
        fill_byte     = it.color ? 8'hFF : 8'h00;
        pg            = it.row / 8;
        sh            = it.row % 8;
        case (it.op)
            OP_FILL_ALL:
            begin
                for (i = 0; i < STORE_SIZE; i++)
                    pixel_bytes[i] = fill_byte;
            end
            OP_FILL_PAGE:
            begin
                if (it.page_number >= PAGE_COUNT)
                    res.status = STATUS_IGNORED;
                else
                    for (i = 0; i < DISPLAY_WIDTH; i++)
                        pixel_bytes[it.page_number * DISPLAY_WIDTH + i] = fill_byte;
            end
            OP_SMALL_COL:
            begin
                if (it.row >= ROW_COUNT || it.column >= DISPLAY_WIDTH)
                    res.status = STATUS_IGNORED;
                else
                begin
                    shifted = {24'h0, it.glyph_bits[7:0]} << sh;
                    blend_byte(pg, it.column, shifted[7:0], it.color);
                    blend_byte(pg + 1, it.column, shifted[15:8], it.color);
                end
            end
            OP_LARGE_COL:
            begin
                if (int'(it.row) + LARGE_ROWS > ROW_COUNT || it.column >= DISPLAY_WIDTH)
                    res.status = STATUS_IGNORED;
                else
                begin
                    shifted = {8'h0, it.glyph_bits} << sh;
                    for (i = 0; i < LARGE_BYTES; i++)
                        blend_byte(pg + i, it.column, shifted[8*i +: 8], it.color);
                end
            end
            OP_READ:
            begin
                if (it.read_index >= STORE_SIZE)
                    res.status = STATUS_IGNORED;
                else
                    res.read_data = pixel_bytes[it.read_index];
            end
            default:
                res.status = STATUS_IGNORED;
        endcase
        return res;
    endfunction

    function automatic item_t make_item(logic [2:0] op, logic [7:0] column, logic [7:0] row,
                                        logic [7:0] page_number, logic color,
                                        logic [23:0] glyph_bits, logic [8:0] read_index);
        item_t it;
        it.op          = op;
        it.column      = column;
        it.row         = row;
        it.page_number = page_number;
        it.color       = color;
        it.glyph_bits  = glyph_bits;
        it.read_index  = read_index;
        return it;
    endfunction

    // Offer one transaction after a random gap and predict it once accepted.
    // Valid stays high between back-to-back transactions.
    task automatic draw_item(item_t it);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        owed_results.push_back(apply_draw_op(it));
    endtask

    // Receiver side: ready drops for random stretches.
    initial
    begin
        int hold;
        hold         = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                result_ready <= 1'b0;
            else if (hold > 0)
            begin
                result_ready <= 1'b0;
                hold--;
            end
            else
            begin
                result_ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result transaction with nothing outstanding: read_data %0h status %0b",
                       result.read_data, result.status);
                mismatch_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (result.read_data !== want.read_data)
                begin
                    $error("read_data: expected %02h, got %02h", want.read_data,
                           result.read_data);
                    mismatch_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0b, got %0b", want.status, result.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Whole-store and single-page fills, including pages past the end.
    task automatic test_fills();
        draw_item(make_item(OP_FILL_ALL, 8'd0, 8'd0, 8'd0, 1'b1, 24'h0, 9'd0));
        draw_item(make_item(OP_READ, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0, 9'd0));
        draw_item(make_item(OP_READ, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0, 9'd511));
        draw_item(make_item(OP_FILL_PAGE, 8'd0, 8'd0, 8'd2, 1'b0, 24'h0, 9'd0));
        draw_item(make_item(OP_FILL_PAGE, 8'd0, 8'd0, 8'd4, 1'b0, 24'h0, 9'd0));
        draw_item(make_item(OP_FILL_PAGE, 8'd0, 8'd0, 8'd255, 1'b0, 24'h0, 9'd0));
        draw_item(make_item(OP_READ, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0, 9'd261));
        draw_item(make_item(OP_FILL_ALL, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0, 9'd0));
    endtask

    // Small columns: aligned, split across two pages, clipped at the bottom,
    // rejected positions, and clearing.
    task automatic test_small_columns();
        draw_item(make_item(OP_SMALL_COL, 8'd0, 8'd0, 8'd0, 1'b1, 24'h0000FF, 9'd0));
        draw_item(make_item(OP_SMALL_COL, 8'd127, 8'd7, 8'd0, 1'b1, 24'hFF00A5, 9'd0));
        draw_item(make_item(OP_SMALL_COL, 8'd64, 8'd31, 8'd0, 1'b1, 24'h0000FF, 9'd0));
        draw_item(make_item(OP_SMALL_COL, 8'd10, 8'd32, 8'd0, 1'b1, 24'h0000FF, 9'd0));
        draw_item(make_item(OP_SMALL_COL, 8'd128, 8'd5, 8'd0, 1'b1, 24'h0000FF, 9'd0));
        draw_item(make_item(OP_SMALL_COL, 8'd127, 8'd7, 8'd0, 1'b0, 24'h000081, 9'd0));
        draw_item(make_item(OP_READ, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0, 9'd255));
    endtask

    // Large columns: four-page span, last legal row, rejected rows and column.
    task automatic test_large_columns();
        draw_item(make_item(OP_LARGE_COL, 8'd3, 8'd0, 8'd0, 1'b1, 24'hFFFFFF, 9'd0));
        draw_item(make_item(OP_LARGE_COL, 8'd4, 8'd7, 8'd0, 1'b1, 24'hABCDEF, 9'd0));
        draw_item(make_item(OP_LARGE_COL, 8'd5, 8'd8, 8'd0, 1'b1, 24'h5A5A5A, 9'd0));
        draw_item(make_item(OP_LARGE_COL, 8'd6, 8'd9, 8'd0, 1'b1, 24'hFFFFFF, 9'd0));
        draw_item(make_item(OP_LARGE_COL, 8'd6, 8'd255, 8'd0, 1'b1, 24'hFFFFFF, 9'd0));
        draw_item(make_item(OP_LARGE_COL, 8'd255, 8'd0, 8'd0, 1'b1, 24'hFFFFFF, 9'd0));
        draw_item(make_item(OP_LARGE_COL, 8'd4, 8'd7, 8'd0, 1'b0, 24'hF0F0F0, 9'd0));
        draw_item(make_item(OP_READ, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0, 9'd388));
    endtask

    task automatic test_spare_ops();
        logic [2:0] op;
        for (op = OP_SPARE_FIRST; op <= OP_SPARE_LAST && op >= OP_SPARE_FIRST; op++)
            draw_item(make_item(op, 8'd1, 8'd1, 8'd1, 1'b1, 24'hFFFFFF, 9'd1));
    endtask

    // Mostly legal drawing and reads on a crowded set of columns, with rare
    // fills and some fully random transactions mixed in.
    task automatic test_random_traffic(int count);
        item_t it;
        int    roll;
        int    n;
        for (n = 0; n < count; n++)
        begin
            it   = make_item(3'($urandom_range(0, 7)), 8'($urandom()), 8'($urandom()),
                             8'($urandom()), 1'($urandom()), 24'($urandom()),
                             9'($urandom()));
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 7)
                it.column = 8'($urandom_range(0, 15));
            else
                it.column = 8'($urandom_range(0, DISPLAY_WIDTH - 1));
            if (roll < 35)
            begin
                it.op  = OP_SMALL_COL;
                it.row = 8'($urandom_range(0, ROW_COUNT - 1));
            end
            else if (roll < 60)
            begin
                it.op  = OP_LARGE_COL;
                it.row = 8'($urandom_range(0, ROW_COUNT - LARGE_ROWS));
            end
            else if (roll < 90)
            begin
                it.op         = OP_READ;
                it.read_index = 9'($urandom_range(0, PAGE_COUNT - 1) * DISPLAY_WIDTH
                                   + it.column);
                if ($urandom_range(0, 3) == 0)
                    it.read_index = 9'($urandom());
            end
            else if (roll < 92)
            begin
                it.op = OP_FILL_PAGE;
                if ($urandom_range(0, 1) == 0)
                    it.page_number = 8'($urandom_range(0, 7));
            end
            else if (roll == 92)
                it.op = OP_FILL_ALL;
            else if (it.op == OP_FILL_ALL && $urandom_range(0, 3) != 0)
                it.op = OP_READ;
            draw_item(it);
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        no_idling      = 1'b0;
        for (int i = 0; i < STORE_SIZE; i++)
            pixel_bytes[i] = 8'h00;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_fills();
        test_small_columns();
        test_large_columns();
        test_spare_ops();
        test_random_traffic(500);
        no_idling = 1'b1;
        test_random_traffic(150);
        no_idling = 1'b0;
        test_random_traffic(470);

        @(negedge clk);
        item_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
